>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL modules.
// Assumes the enclosing module has clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

>>> hw/rtl/spasp_pkg.sv
// Shared types and constants for the addressed SPI servo pulse unit.
// No dependencies.
package spasp_pkg;

  localparam int unsigned CHANNEL_COUNT = 8;
  localparam int unsigned RX_DEPTH      = 20;
  localparam int unsigned RX_IDX_W      = $clog2(RX_DEPTH + 1);

  localparam logic [7:0] EOD_BYTE = 8'hED;
  localparam logic [7:0] ACK_BYTE = 8'hAC;
  localparam logic [7:0] POLL_REPLY = 8'h00;
  localparam logic [1:0] FOLLOW_START = 2'd2;

  // reset values of the configuration registers
  localparam logic [15:0] FRAME_TICKS_RST  = 16'd2500;
  localparam logic [9:0]  LEAD_TICKS_RST   = 10'd125;
  localparam logic [7:0]  SPAN_TICKS_RST   = 8'd125;
  localparam logic [7:0]  ADDRESS_HIGH_RST = 8'hFB;
  localparam logic [7:0]  ADDRESS_LOW_RST  = 8'hBF;

  localparam int unsigned PADDR_W = 5;

  typedef enum logic [2:0] {
    REG_FRAME_TICKS  = 3'd0,
    REG_LEAD_TICKS   = 3'd1,
    REG_SPAN_TICKS   = 3'd2,
    REG_ADDRESS_HIGH = 3'd3,
    REG_ADDRESS_LOW  = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] frame_ticks;
    logic [9:0]  lead_ticks;
    logic [7:0]  span_ticks;
    logic [7:0]  address_high;
    logic [7:0]  address_low;
  } cfg_t;

  typedef logic [CHANNEL_COUNT-1:0][7:0] width_arr_t;

  // SPI side results of one item
  typedef struct packed {
    logic       miso_enable;
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       widths_loaded;
  } spi_res_t;

  localparam int unsigned OUT_BITS = 20;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // result item, lowest field in the lowest bits
  typedef struct packed {
    logic [OUT_TDATA_W-OUT_BITS-1:0] pad;
    logic       busy_res;
    logic       widths_loaded;
    logic [7:0] reply_byte;
    logic       reply_valid;
    logic       miso_enable;
    logic [7:0] pwm_out;
  } out_item_t;

endpackage

>>> hw/rtl/spasp_cfg_regs.sv
// APB-style configuration registers of the servo pulse unit.
// Depends on spasp_pkg.
module spasp_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [spasp_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output spasp_pkg::cfg_t              cfg_o
);

  spasp_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[spasp_pkg::PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        spasp_pkg::REG_FRAME_TICKS:  cfg_d.frame_ticks  = pwdata[15:0];
        spasp_pkg::REG_LEAD_TICKS:   cfg_d.lead_ticks   = pwdata[9:0];
        spasp_pkg::REG_SPAN_TICKS:   cfg_d.span_ticks   = pwdata[7:0];
        spasp_pkg::REG_ADDRESS_HIGH: cfg_d.address_high = pwdata[7:0];
        spasp_pkg::REG_ADDRESS_LOW:  cfg_d.address_low  = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      spasp_pkg::REG_FRAME_TICKS:  prdata = {16'd0, cfg_q.frame_ticks};
      spasp_pkg::REG_LEAD_TICKS:   prdata = {22'd0, cfg_q.lead_ticks};
      spasp_pkg::REG_SPAN_TICKS:   prdata = {24'd0, cfg_q.span_ticks};
      spasp_pkg::REG_ADDRESS_HIGH: prdata = {24'd0, cfg_q.address_high};
      spasp_pkg::REG_ADDRESS_LOW:  prdata = {24'd0, cfg_q.address_low};
      default:                     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_ticks  <= spasp_pkg::FRAME_TICKS_RST;
      cfg_q.lead_ticks   <= spasp_pkg::LEAD_TICKS_RST;
      cfg_q.span_ticks   <= spasp_pkg::SPAN_TICKS_RST;
      cfg_q.address_high <= spasp_pkg::ADDRESS_HIGH_RST;
      cfg_q.address_low  <= spasp_pkg::ADDRESS_LOW_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/spasp_spi_ctrl.sv
// Addressed SPI frame protocol: address match, receive store, width registers.
// Depends on spasp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module spasp_spi_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,   // one SPI byte item is processed
  input  logic [7:0]            byte_i,
  input  logic                  free_i,   // no pulse trailing window active
  input  spasp_pkg::cfg_t       cfg_i,
  output spasp_pkg::spi_res_t   res_o,
  output spasp_pkg::width_arr_t widths_o  // widths after this item
);

  localparam int unsigned CH = spasp_pkg::CHANNEL_COUNT;
  localparam int unsigned IW = spasp_pkg::RX_IDX_W;

  logic [1:0]    follow_q, follow_d;
  logic          matched_q, matched_d;
  logic          sel_q, sel_d;
  logic          miso_q, miso_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [7:0]    store_q [1:CH];
  logic [7:0]    store_d [1:CH];
  spasp_pkg::width_arr_t widths_q, widths_d;

  // only store entries 1..CH are ever read back; the rest only advance the index
  always_comb begin
    follow_d  = follow_q;
    matched_d = matched_q;
    sel_d     = sel_q;
    miso_d    = miso_q;
    idx_d     = idx_q;
    store_d   = store_q;
    widths_d  = widths_q;
    res_o     = '0;
    if (step_i) begin
      follow_d = (follow_q != 2'd0) ? follow_q - 2'd1 : 2'd0;
      if (byte_i == cfg_i.address_high && free_i) follow_d = spasp_pkg::FOLLOW_START;
      if (byte_i == cfg_i.address_low && follow_d != 2'd0) begin
        matched_d = 1'b1;
        idx_d     = '0;
        sel_d     = 1'b1;
      end
      if (matched_d) begin
        if (byte_i == cfg_i.address_low) begin
          // address poll: transmit buffer is never filled
          miso_d            = 1'b1;
          res_o.reply_valid = 1'b1;
          res_o.reply_byte  = spasp_pkg::POLL_REPLY;
        end else begin
          if (sel_d) begin
            if (byte_i == spasp_pkg::EOD_BYTE) begin
              idx_d = '0;
              sel_d = 1'b0;
              for (int c = 1; c <= CH; c++) widths_d[c-1] = store_q[c];
              res_o.reply_valid   = 1'b1;
              res_o.reply_byte    = spasp_pkg::ACK_BYTE;
              res_o.widths_loaded = 1'b1;
            end
            if (idx_d < IW'(spasp_pkg::RX_DEPTH)) begin
              for (int c = 1; c <= CH; c++) begin
                if (idx_d == IW'(c)) store_d[c] = byte_i;
              end
              idx_d = idx_d + IW'(1);
            end
          end
          if (byte_i == spasp_pkg::ACK_BYTE) begin
            miso_d    = 1'b0;
            matched_d = 1'b0;
            idx_d     = '0;
          end
        end
      end
    end
    res_o.miso_enable = miso_d;
  end

  assign widths_o = widths_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      follow_q  <= 2'd0;
      matched_q <= 1'b0;
      sel_q     <= 1'b0;
      miso_q    <= 1'b0;
      idx_q     <= '0;
      widths_q  <= '0;
      for (int c = 1; c <= CH; c++) store_q[c] <= 8'd0;
    end else begin
      follow_q  <= follow_d;
      matched_q <= matched_d;
      sel_q     <= sel_d;
      miso_q    <= miso_d;
      idx_q     <= idx_d;
      widths_q  <= widths_d;
      store_q   <= store_d;
    end
  end

  `ASSERT_NEVER(a_follow_range, follow_q == 2'd3)
  `ASSERT_NEVER(a_miso_needs_match, miso_q && !matched_q)
  `ASSERT_NEVER(a_idx_bound, idx_q > IW'(spasp_pkg::RX_DEPTH))
  `ASSERT_PROP(a_widths_on_eod, !res_o.widths_loaded || (step_i && byte_i == spasp_pkg::EOD_BYTE))

endmodule

>>> hw/rtl/spasp_pulse_gen.sv
// Frame tick counter and eight-channel servo pulse compare.
// Depends on spasp_pkg.
module spasp_pulse_gen (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,   // one tick item is processed
  input  spasp_pkg::cfg_t       cfg_i,
  input  spasp_pkg::width_arr_t widths_i,
  output logic                  free_o,   // current count outside the busy window
  output logic [7:0]            pwm_o,    // after this item
  output logic                  busy_o    // after this item
);

  localparam int unsigned CH = spasp_pkg::CHANNEL_COUNT;

  logic [15:0] tick_q, tick_d;
  logic [16:0] tick_inc;
  logic [16:0] lead_ext, win_end;

  assign tick_inc = {1'b0, tick_q} + 17'd1;
  assign lead_ext = {7'd0, cfg_i.lead_ticks};
  assign win_end  = lead_ext + {9'd0, cfg_i.span_ticks};

  always_comb begin
    tick_d = tick_q;
    if (step_i) begin
      if (tick_inc >= {1'b0, cfg_i.frame_ticks}) tick_d = 16'd0;
      else tick_d = tick_inc[15:0];
    end
  end

  assign free_o = !({1'b0, tick_q} >= lead_ext && {1'b0, tick_q} < win_end);
  assign busy_o = {1'b0, tick_d} >= lead_ext && {1'b0, tick_d} < win_end;

  always_comb begin
    logic [7:0] w;
    pwm_o = 8'd0;
    for (int c = 0; c < CH; c++) begin
      w = (widths_i[c] > cfg_i.span_ticks) ? cfg_i.span_ticks : widths_i[c];
      if (w == 8'd0) w = 8'd1;
      pwm_o[c] = {1'b0, tick_d} < lead_ext + {9'd0, w};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tick_q <= 16'd0;
    else tick_q <= tick_d;
  end

endmodule

>>> hw/rtl/spi_addressed_servo_pwm_unit.sv
// Top level of the addressed SPI servo pulse unit: item stream, APB registers.
// Depends on spasp_pkg, spasp_cfg_regs, spasp_spi_ctrl, spasp_pulse_gen.
//
// Every input item (an SPI byte or a time tick) yields exactly one result item.
// Throughput is one item per clock cycle while the result side does not stall.
// An accepted item sits in the input register and is then offered from the
// result register. The state update of the SPI protocol, the tick counter and
// the eight pulse compares are computed combinationally between those two
// registers. While a result waits downstream with the input register full, the
// input side is held; it accepts again in the cycle the result is taken.
// The user must write the configuration registers over the APB port only while
// no items are in flight; the block itself does not enforce this.
`include "assert_macros.svh"
module spi_addressed_servo_pwm_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] spi_byte
  input  logic                           s_axis_tuser,  // [0] kind (1 = tick)
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] pwm_out, [8] miso_enable, [9] reply_valid, [17:10] reply_byte,
  // [18] widths_loaded, [19] busy_res, [23:20] zero
  output logic [spasp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [spasp_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic       in_valid_q;
  logic       in_kind_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  spasp_pkg::out_item_t res_q, res_d;
  logic       advance;
  logic       free;
  logic [7:0] pwm;
  logic       busy;
  spasp_pkg::cfg_t       cfg;
  spasp_pkg::spi_res_t   spi_res;
  spasp_pkg::width_arr_t widths;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  spasp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  spasp_spi_ctrl u_spi (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance && !in_kind_q),
    .byte_i   (in_byte_q),
    .free_i   (free),
    .cfg_i    (cfg),
    .res_o    (spi_res),
    .widths_o (widths)
  );

  spasp_pulse_gen u_pulse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance && in_kind_q),
    .cfg_i    (cfg),
    .widths_i (widths),
    .free_o   (free),
    .pwm_o    (pwm),
    .busy_o   (busy)
  );

  always_comb begin
    res_d               = '0;
    res_d.pwm_out       = pwm;
    res_d.miso_enable   = spi_res.miso_enable;
    res_d.reply_valid   = spi_res.reply_valid;
    res_d.reply_byte    = spi_res.reply_byte;
    res_d.widths_loaded = spi_res.widths_loaded;
    res_d.busy_res      = busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_kind_q <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
    if (advance) res_q <= res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;

  `ASSERT_NEVER(a_ready_only_stalls_full, !s_axis_tready && !in_valid_q)
  `ASSERT_NEVER(a_reply_zero_when_idle, out_valid_q && !res_q.reply_valid && res_q.reply_byte != 8'd0)
  `ASSERT_NEVER(a_loaded_acks, out_valid_q && res_q.widths_loaded && res_q.reply_byte != spasp_pkg::ACK_BYTE)
  `ASSERT_PROP(a_tick_no_reply, advance && in_kind_q |=> !res_q.reply_valid)

endmodule
